>>> design/slas_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sparse linear argmax scorer.
// No dependencies; used by the top module, slas_mul and slas_score.
package slas_pkg;

    // Fixed field widths of the item and result beats
    localparam int VALUE_W = 16;
    localparam int FID_W   = 12;
    localparam int SUM_W   = 40;
    localparam int IDX_W   = 8;

    // Saturation bounds of the running score
    localparam logic signed [SUM_W-1:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 40'sh80_0000_0000;

    // Control carried along with a feature beat through the pipeline
    typedef struct packed {
        logic valid;
        logic eoi;
        logic eos;
    } t_beat_ctl;

endpackage

>>> design/sparse_linear_argmax_scorer.sv
`timescale 1ns / 1ps
// Sparse linear scorer with argmax over a candidate set.
// Input channel: i_in_valid / o_in_stall carry weight-write beats (mode 0)
// and feature beats (mode 1). An in-range weight beat writes the weight RAM and gives
// no result. A feature beat reads its weight, multiplies it by the value and
// adds it into a saturating 40-bit score; end_of_instance closes the score
// and compares it with the best so far (earliest instance wins ties).
// Output channel: o_out_valid / i_out_stall carry one result beat per set:
// winning index, its score and a saturation flag.
// Result path: the feature beat carrying end_of_set passes the RAM read, then
// the multiply, then the accumulate into the result register.
// Throughput: one beat per cycle while o_in_stall is low; the weight RAM has one
// write and one read port and the accumulator loop holds no extra register.
// Receiver stall: the result register holds its beat; the pipeline freezes
// only when a further set result reaches a full, stalled result register.
// Reset clears the score, best, count and saturation state; the weight RAM
// is not cleared and must be written before it is read.
// Depends on slas_pkg, slas_ram, slas_mul and slas_score.
module sparse_linear_argmax_scorer #(
    parameter int NUM_FEATURES  = 4096,
    parameter int MAX_INSTANCES = 256,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic [slas_pkg::FID_W-1:0]          i_feature_id,
    input  logic signed [slas_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_end_of_instance,
    input  logic                                i_end_of_set,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [slas_pkg::IDX_W-1:0]          o_best_index,
    output logic signed [slas_pkg::SUM_W-1:0]   o_best_total,
    output logic                                o_saturated
);

    localparam int AW   = $clog2(NUM_FEATURES);
    localparam int CMPW = ((AW > slas_pkg::FID_W) ? AW : slas_pkg::FID_W) + 1;
    localparam int PW   = slas_pkg::VALUE_W + WEIGHT_BITS;
    localparam logic signed [32:0] W_HI = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

    logic                          adv;
    logic                          accept;
    logic [CMPW-1:0]               fid_ext;
    logic                          hit;
    logic [AW-1:0]                 addr;
    logic signed [32:0]            value_ext;
    logic signed [32:0]            w_clamp;
    logic signed [WEIGHT_BITS-1:0] w_wdata;
    logic signed [WEIGHT_BITS-1:0] w_rdata;
    slas_pkg::t_beat_ctl           s2_ctl;
    logic signed [PW-1:0]          s2_prod;

    // Decode the input beat: range check, address and clamped weight
    always_comb begin
        accept    = i_in_valid && adv;
        fid_ext   = CMPW'(i_feature_id);
        hit       = fid_ext < CMPW'(NUM_FEATURES);
        addr      = fid_ext[AW-1:0];
        value_ext = 33'(i_value);
        priority if (value_ext > W_HI) begin
            w_clamp = W_HI;
        end else if (value_ext < W_LO) begin
            w_clamp = W_LO;
        end else begin
            w_clamp = value_ext;
        end
        w_wdata = w_clamp[WEIGHT_BITS-1:0];
    end

    slas_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (NUM_FEATURES)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (accept && !i_mode && hit),
        .i_waddr (addr),
        .i_wdata (w_wdata),
        .i_re    (accept && i_mode),
        .i_raddr (addr),
        .o_rdata (w_rdata)
    );

    slas_mul #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_load   (accept && i_mode),
        .i_value  (i_value),
        .i_hit    (hit),
        .i_eoi    (i_end_of_instance),
        .i_eos    (i_end_of_set),
        .i_weight (w_rdata),
        .o_ctl    (s2_ctl),
        .o_prod   (s2_prod)
    );

    slas_score #(
        .WEIGHT_BITS   (WEIGHT_BITS),
        .MAX_INSTANCES (MAX_INSTANCES)
    ) u_score (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (s2_ctl),
        .i_prod       (s2_prod),
        .i_out_stall  (i_out_stall),
        .o_adv        (adv),
        .o_out_valid  (o_out_valid),
        .o_best_index (o_best_index),
        .o_best_total (o_best_total),
        .o_saturated  (o_saturated)
    );

    assign o_in_stall = !adv;

endmodule

>>> design/slas_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module slas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read data (held while no read is issued)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/slas_mul.sv
`timescale 1ns / 1ps
// Multiply stage: pairs each feature value with its weight read from the RAM
// and registers the Q16.16 product. Depends on slas_pkg.
module slas_mul #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_load,
    input  logic signed [slas_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_hit,
    input  logic                                i_eoi,
    input  logic                                i_eos,
    input  logic signed [WEIGHT_BITS-1:0]       i_weight,
    output slas_pkg::t_beat_ctl                 o_ctl,
    output logic signed [slas_pkg::VALUE_W+WEIGHT_BITS-1:0] o_prod
);

    localparam int PW = slas_pkg::VALUE_W + WEIGHT_BITS;

    slas_pkg::t_beat_ctl                 r_s1_ctl;
    logic signed [slas_pkg::VALUE_W-1:0] r_s1_value;
    logic                                r_s1_hit;
    slas_pkg::t_beat_ctl                 r_s2_ctl;
    logic signed [PW-1:0]                r_prod;

    logic signed [WEIGHT_BITS-1:0] weight;
    logic signed [PW-1:0]          n_prod;

    // Out-of-range feature reads as weight zero
    always_comb begin
        weight = r_s1_hit ? i_weight : '0;
        n_prod = PW'(r_s1_value) * PW'(weight);
    end

    // Advance both stages together; hold everything on a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
            r_s2_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_ctl.valid <= i_load;
            r_s1_ctl.eoi   <= i_eoi | i_eos;
            r_s1_ctl.eos   <= i_eos;
            r_s1_value     <= i_value;
            r_s1_hit       <= i_hit;
            r_s2_ctl       <= r_s1_ctl;
            r_prod         <= n_prod;
        end
    end

    assign o_ctl  = r_s2_ctl;
    assign o_prod = r_prod;

endmodule

>>> design/slas_score.sv
`timescale 1ns / 1ps
// Score stage: saturating accumulation, per-instance argmax and the result
// register. Depends on slas_pkg.
module slas_score #(
    parameter int WEIGHT_BITS   = 16,
    parameter int MAX_INSTANCES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  slas_pkg::t_beat_ctl                 i_ctl,
    input  logic signed [slas_pkg::VALUE_W+WEIGHT_BITS-1:0] i_prod,
    input  logic                                i_out_stall,
    output logic                                o_adv,
    output logic                                o_out_valid,
    output logic [slas_pkg::IDX_W-1:0]          o_best_index,
    output logic signed [slas_pkg::SUM_W-1:0]   o_best_total,
    output logic                                o_saturated
);

    localparam int PW  = slas_pkg::VALUE_W + WEIGHT_BITS;
    localparam int SW  = ((PW > slas_pkg::SUM_W) ? PW : slas_pkg::SUM_W) + 1;
    localparam int PIW = $clog2(MAX_INSTANCES);
    localparam int CW  = $clog2(MAX_INSTANCES + 1);
    localparam int EXW = (PIW > slas_pkg::IDX_W) ? PIW : slas_pkg::IDX_W;

    logic signed [slas_pkg::SUM_W-1:0] r_run, n_run;
    logic signed [slas_pkg::SUM_W-1:0] r_top, n_top;
    logic [PIW-1:0]                    r_pos, n_pos;
    logic [CW-1:0]                     r_cnt, n_cnt;
    logic                              r_sat, n_sat;
    logic                              r_out_valid, n_out_valid;
    logic [slas_pkg::IDX_W-1:0]        r_best_index, n_best_index;
    logic signed [slas_pkg::SUM_W-1:0] r_best_total, n_best_total;
    logic                              r_out_sat, n_out_sat;

    logic signed [SW-1:0]              sum_w;
    logic signed [slas_pkg::SUM_W-1:0] sum_sat;
    logic                              ovf;
    logic                              room;
    logic                              take;
    logic                              adv;
    logic                              fire;
    logic signed [slas_pkg::SUM_W-1:0] top_upd;
    logic [PIW-1:0]                    pos_upd;
    logic [EXW-1:0]                    pos_ext;

    always_comb begin
        // Stall only when a set result meets a full, stalled result register
        adv  = !(i_ctl.valid && i_ctl.eos && r_out_valid && i_out_stall);
        fire = i_ctl.valid && adv;

        // Saturating add of the product into the running score
        sum_w = SW'(r_run) + SW'(i_prod);
        ovf   = 1'b1;
        priority if (sum_w > SW'(slas_pkg::SUM_MAX)) begin
            sum_sat = slas_pkg::SUM_MAX;
        end else if (sum_w < SW'(slas_pkg::SUM_MIN)) begin
            sum_sat = slas_pkg::SUM_MIN;
        end else begin
            sum_sat = sum_w[slas_pkg::SUM_W-1:0];
            ovf     = 1'b0;
        end

        // Strict greater-than; the first instance of a set is always taken as best so far
        room    = r_cnt < CW'(MAX_INSTANCES);
        take    = room && ((r_cnt == '0) || (sum_sat > r_top));
        top_upd = take ? sum_sat : r_top;
        pos_upd = take ? r_cnt[PIW-1:0] : r_pos;
        pos_ext = EXW'(pos_upd);

        n_run        = r_run;
        n_top        = r_top;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_sat        = r_sat;
        n_out_valid  = r_out_valid && i_out_stall;
        n_best_index = r_best_index;
        n_best_total = r_best_total;
        n_out_sat    = r_out_sat;

        if (fire) begin
            n_sat = r_sat | ovf;
            if (i_ctl.eoi) begin
                n_run = '0;
                n_top = top_upd;
                n_pos = pos_upd;
                n_cnt = room ? r_cnt + CW'(1) : r_cnt;
            end else begin
                n_run = sum_sat;
            end
            // Emit the set result and clear the per-set state
            if (i_ctl.eos) begin
                n_out_valid  = 1'b1;
                n_best_index = pos_ext[slas_pkg::IDX_W-1:0];
                n_best_total = top_upd;
                n_out_sat    = r_sat | ovf;
                n_top        = '0;
                n_pos        = '0;
                n_cnt        = '0;
                n_sat        = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_top       <= '0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_run       <= n_run;
            r_top       <= n_top;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_best_index <= n_best_index;
        r_best_total <= n_best_total;
        r_out_sat    <= n_out_sat;
    end

    assign o_adv        = adv;
    assign o_out_valid  = r_out_valid;
    assign o_best_index = r_best_index;
    assign o_best_total = r_best_total;
    assign o_saturated  = r_out_sat;

endmodule
